/* hdl/kitc_pkg.sv */
package kitc_pkg;

	localparam int KMER_W = 64;
	localparam int OUT_ID_W = 20;
	localparam int COUNT_W = 16;
	localparam int CFG_W = 5;
	localparam int REG_IDX_W = 1;
	localparam int PROBE_DEPTH = 8;
	localparam int PROBE_W = 3;
	localparam int HASH_SHIFT = 32;
	localparam int DIGIT_W = 16;
	localparam int HASH_DIGITS = KMER_W / DIGIT_W;
	localparam logic [KMER_W-1:0] HASH_MULT = 64'h9E3779B97F4A7C15;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
	localparam logic [CFG_W-1:0] TOP_LIMIT_RST = 5'd8;
	localparam logic [CFG_W-1:0] POSTING_LIMIT_RST = 5'd16;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_TOP_LIMIT,
		REG_POSTING_LIMIT
	} kitc_reg_t;

	typedef enum logic [4:0] {
		OP_NOP,
		OP_CLEAR,
		OP_LOAD,
		OP_HASH,
		OP_PROBE_RD,
		OP_PROBE_CHK,
		OP_POST_RD,
		OP_POST_CAP,
		OP_HIT_RD,
		OP_HIT_CHK,
		OP_HIT_NEW,
		OP_POST_NEXT,
		OP_INSERT,
		OP_SEL_START,
		OP_SEL_INIT,
		OP_SEL_RD,
		OP_SEL_CHK,
		OP_SEL_EMIT,
		OP_FLUSH,
		OP_READ_DONE
	} kitc_op_t;

	typedef struct packed {
		kitc_op_t op;
	} kitc_cmd_t;

	typedef struct packed {
		logic clr_done;
		logic hash_done;
		logic probe_hit;
		logic probe_last;
		logic is_ref;
		logic present;
		logic read_end;
		logic post_more;
		logic ins_ok;
		logic hit_scan_end;
		logic hit_match;
		logic sel_more;
		logic sel_got;
		logic pend_valid;
		logic out_free;
	} kitc_stat_t;

endpackage

/* hdl/kitc_if.sv */
interface kitc_in_if;
	import kitc_pkg::*;
	logic              valid;
	logic              ready;
	logic              command;
	logic [KMER_W-1:0] kmer_value;
	logic              kmer_present;
	logic              read_end;
	logic              accept_reference;

	modport source (output valid, command, kmer_value, kmer_present, read_end,
		accept_reference, input ready);
	modport sink (input valid, command, kmer_value, kmer_present, read_end,
		accept_reference, output ready);
endinterface

interface kitc_out_if;
	import kitc_pkg::*;
	logic                valid;
	logic                ready;
	logic [OUT_ID_W-1:0] read_number;
	logic [OUT_ID_W-1:0] candidate_id;
	logic [COUNT_W-1:0]  shared_count;
	logic                no_candidate;
	logic                overflow;
	logic                last_candidate;

	modport source (output valid, read_number, candidate_id, shared_count, no_candidate,
		overflow, last_candidate, input ready);
	modport sink (input valid, read_number, candidate_id, shared_count, no_candidate,
		overflow, last_candidate, output ready);
endinterface

/* hdl/kitc_ctrl.sv */
module kitc_ctrl import kitc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  kitc_stat_t stat,
	output kitc_cmd_t  cmd
);

	typedef enum logic [4:0] {
		S_CLEAR,
		S_IDLE,
		S_LOADED,
		S_HASH,
		S_PRB_RD,
		S_PRB_CHK,
		S_POST_CHK,
		S_POST_RD,
		S_POST_CAP,
		S_HIT_RD,
		S_HIT_CHK,
		S_HIT_NEW,
		S_POST_NEXT,
		S_INS,
		S_END,
		S_SEL_PASS,
		S_SEL_RD,
		S_SEL_CHK,
		S_SEL_DONE,
		S_FLUSH
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd.op = OP_NOP;
		unique case (state_q)
			S_CLEAR: begin
				cmd.op = OP_CLEAR;
				if (stat.clr_done) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.op = OP_LOAD;
					state_d = S_LOADED;
				end
			end
			S_LOADED: state_d = stat.present ? S_HASH : S_END;
			S_HASH: begin
				cmd.op = OP_HASH;
				if (stat.hash_done) state_d = S_PRB_RD;
			end
			S_PRB_RD: begin
				cmd.op = OP_PROBE_RD;
				state_d = S_PRB_CHK;
			end
			S_PRB_CHK: begin
				cmd.op = OP_PROBE_CHK;
				if (stat.probe_hit || stat.probe_last)
					state_d = stat.is_ref ? S_INS : S_POST_CHK;
				else
					state_d = S_PRB_RD;
			end
			S_POST_CHK: begin
				if (stat.post_more) state_d = S_POST_RD;
				else if (stat.ins_ok) state_d = S_INS;
				else state_d = S_END;
			end
			S_POST_RD: begin
				cmd.op = OP_POST_RD;
				state_d = S_POST_CAP;
			end
			S_POST_CAP: begin
				cmd.op = OP_POST_CAP;
				state_d = S_HIT_RD;
			end
			S_HIT_RD: begin
				if (stat.hit_scan_end) begin
					state_d = S_HIT_NEW;
				end else begin
					cmd.op = OP_HIT_RD;
					state_d = S_HIT_CHK;
				end
			end
			S_HIT_CHK: begin
				cmd.op = OP_HIT_CHK;
				state_d = stat.hit_match ? S_POST_NEXT : S_HIT_RD;
			end
			S_HIT_NEW: begin
				cmd.op = OP_HIT_NEW;
				state_d = S_POST_NEXT;
			end
			S_POST_NEXT: begin
				cmd.op = OP_POST_NEXT;
				state_d = S_POST_CHK;
			end
			S_INS: begin
				cmd.op = OP_INSERT;
				state_d = S_END;
			end
			S_END: begin
				if (!stat.read_end) begin
					state_d = S_IDLE;
				end else if (stat.is_ref) begin
					cmd.op = OP_READ_DONE;
					state_d = S_IDLE;
				end else begin
					cmd.op = OP_SEL_START;
					state_d = S_SEL_PASS;
				end
			end
			S_SEL_PASS: begin
				if (stat.sel_more) begin
					cmd.op = OP_SEL_INIT;
					state_d = S_SEL_RD;
				end else begin
					state_d = S_FLUSH;
				end
			end
			S_SEL_RD: begin
				if (stat.hit_scan_end) begin
					state_d = S_SEL_DONE;
				end else begin
					cmd.op = OP_SEL_RD;
					state_d = S_SEL_CHK;
				end
			end
			S_SEL_CHK: begin
				cmd.op = OP_SEL_CHK;
				state_d = S_SEL_RD;
			end
			S_SEL_DONE: begin
				if (!stat.sel_got) begin
					state_d = S_FLUSH;
				end else if (!stat.pend_valid || stat.out_free) begin
					cmd.op = OP_SEL_EMIT;
					state_d = S_SEL_PASS;
				end
			end
			S_FLUSH: begin
				if (stat.out_free) begin
					cmd.op = OP_FLUSH;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_CLEAR;
		else state_q <= state_d;
	end

endmodule

/* hdl/kitc_dp.sv */
module kitc_dp import kitc_pkg::*; #(
	parameter int INDEX_ENTRIES     = 4096,
	parameter int POSTINGS_PER_KMER = 16,
	parameter int HIT_ENTRIES       = 256,
	parameter int TOP_MAX           = 16,
	parameter int ID_BITS           = 20
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  kitc_cmd_t            cmd,
	output kitc_stat_t           stat,
	input  logic                 command,
	input  logic [KMER_W-1:0]    kmer_value,
	input  logic                 kmer_present,
	input  logic                 read_end,
	input  logic                 accept_reference,
	output logic                 res_valid,
	input  logic                 res_ready,
	output logic [OUT_ID_W-1:0]  read_number,
	output logic [OUT_ID_W-1:0]  candidate_id,
	output logic [COUNT_W-1:0]   shared_count,
	output logic                 no_candidate,
	output logic                 overflow,
	output logic                 last_candidate
);

	localparam int IW   = $clog2(INDEX_ENTRIES);
	localparam int PC_W = $clog2(POSTINGS_PER_KMER + 1);
	localparam int PA_W = $clog2(INDEX_ENTRIES * POSTINGS_PER_KMER);
	localparam int HA_W = $clog2(HIT_ENTRIES);
	localparam int HU_W = $clog2(HIT_ENTRIES + 1);
	localparam int TN_W = $clog2(TOP_MAX + 1);

	typedef struct packed {
		logic              valid;
		logic [PC_W-1:0]   cnt;
		logic [KMER_W-1:0] key;
	} idx_entry_t;

	typedef struct packed {
		logic [ID_BITS-1:0] id;
		logic [COUNT_W-1:0] cnt;
	} hit_entry_t;

	// memories
	idx_entry_t         idx_mem [INDEX_ENTRIES];
	logic [ID_BITS-1:0] post_mem [INDEX_ENTRIES * POSTINGS_PER_KMER];
	hit_entry_t         hit_mem [HIT_ENTRIES];

	idx_entry_t         idx_rd_q, idx_wd;
	logic               idx_we;
	logic [IW-1:0]      idx_wa;
	logic [ID_BITS-1:0] post_rd_q;
	logic               post_we;
	logic [PA_W-1:0]    post_wa, post_ra;
	hit_entry_t         hit_rd_q, hit_wd;
	logic               hit_we;
	logic [HA_W-1:0]    hit_wa;

	// control and payload registers
	logic [CFG_W-1:0]    top_q, plim_q;
	logic [KMER_W-1:0]   kmer_q;
	logic                present_q, end_q;
	logic                in_read_q, is_ref_q, read_acc_q;
	logic [ID_BITS-1:0]  ref_id_q, ref_cnt_q;
	logic [OUT_ID_W-1:0] read_cnt_q;
	logic                ovf_q;
	logic [HU_W-1:0]     hit_used_q, i_q;
	logic [KMER_W-1:0]   acc_q;
	logic [1:0]          hd_q;
	logic [PROBE_W-1:0]  p_q;
	logic [IW-1:0]       slot_q, clr_q;
	logic                found_q, free_q;
	logic [PC_W-1:0]     card_q, j_q;
	logic [PA_W-1:0]     post_base_q;
	logic [ID_BITS-1:0]  cur_id_q;
	logic                got_q, have_prev_q, pend_valid_q;
	logic [ID_BITS-1:0]  best_id_q, prev_id_q, pend_id_q;
	logic [COUNT_W-1:0]  best_cnt_q, prev_cnt_q, pend_cnt_q;
	logic [TN_W-1:0]     n_q;
	logic                res_valid_q;
	logic [OUT_ID_W-1:0] res_rn_q, res_id_q;
	logic [COUNT_W-1:0]  res_cnt_q;
	logic                res_none_q, res_ovf_q, res_last_q;

	logic [KMER_W-1:0]   hash_part;
	logic [IW-1:0]       probe_addr;
	logic                key_match, ins_room, hit_full, eligible, better, out_free;
	logic                res_load;
	logic [7:0]          lim8;
	logic [ID_BITS+OUT_ID_W-1:0] cid_ext;

	assign hash_part  = KMER_W'(kmer_q[hd_q*DIGIT_W +: DIGIT_W]) * HASH_MULT;
	assign probe_addr = acc_q[HASH_SHIFT +: IW] + IW'(p_q);
	assign key_match  = idx_rd_q.valid && (idx_rd_q.key == kmer_q);
	assign ins_room   = (found_q || free_q) && (card_q < PC_W'(POSTINGS_PER_KMER));
	assign hit_full   = (hit_used_q == HU_W'(HIT_ENTRIES));
	assign out_free   = !res_valid_q || res_ready;
	assign res_load   = ((cmd.op == OP_SEL_EMIT) && pend_valid_q) || (cmd.op == OP_FLUSH);
	assign cid_ext    = {{OUT_ID_W{1'b0}}, pend_id_q};
	assign lim8       = ({3'b000, top_q} > 8'(TOP_MAX)) ? 8'(TOP_MAX) : {3'b000, top_q};

	// top selection: strictly below the previous pick, then best of the rest
	assign eligible = !have_prev_q || (hit_rd_q.cnt < prev_cnt_q) ||
		((hit_rd_q.cnt == prev_cnt_q) && (hit_rd_q.id > prev_id_q));
	assign better = !got_q || (hit_rd_q.cnt > best_cnt_q) ||
		((hit_rd_q.cnt == best_cnt_q) && (hit_rd_q.id < best_id_q));

	always_comb begin
		idx_we  = (cmd.op == OP_CLEAR) || ((cmd.op == OP_INSERT) && ins_room);
		idx_wa  = (cmd.op == OP_CLEAR) ? clr_q : slot_q;
		idx_wd  = '0;
		if (cmd.op != OP_CLEAR) begin
			idx_wd.valid = 1'b1;
			idx_wd.cnt   = card_q + PC_W'(1);
			idx_wd.key   = kmer_q;
		end
		post_we = (cmd.op == OP_INSERT) && ins_room;
		post_wa = post_base_q + PA_W'(card_q);
		post_ra = post_base_q + PA_W'(j_q);
		hit_we  = 1'b0;
		hit_wa  = i_q[HA_W-1:0];
		hit_wd.id  = cur_id_q;
		hit_wd.cnt = COUNT_W'(1);
		if ((cmd.op == OP_HIT_CHK) && (hit_rd_q.id == cur_id_q)) begin
			hit_we = 1'b1;
			hit_wd.cnt = (hit_rd_q.cnt == COUNT_MAX) ? hit_rd_q.cnt
				: hit_rd_q.cnt + COUNT_W'(1);
		end else if ((cmd.op == OP_HIT_NEW) && !hit_full) begin
			hit_we = 1'b1;
			hit_wa = hit_used_q[HA_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (idx_we) idx_mem[idx_wa] <= idx_wd;
		idx_rd_q <= idx_mem[probe_addr];
	end

	always_ff @(posedge clk) begin
		if (post_we) post_mem[post_wa] <= ref_id_q;
		post_rd_q <= post_mem[post_ra];
	end

	always_ff @(posedge clk) begin
		if (hit_we) hit_mem[hit_wa] <= hit_wd;
		hit_rd_q <= hit_mem[i_q[HA_W-1:0]];
	end

	always_comb begin
		stat.clr_done     = (clr_q == IW'(INDEX_ENTRIES - 1));
		stat.hash_done    = (hd_q == 2'(HASH_DIGITS - 1));
		stat.probe_hit    = !idx_rd_q.valid || key_match;
		stat.probe_last   = (p_q == PROBE_W'(PROBE_DEPTH - 1));
		stat.is_ref       = is_ref_q;
		stat.present      = present_q;
		stat.read_end     = end_q;
		stat.post_more    = (j_q < card_q);
		stat.ins_ok       = is_ref_q || (read_acc_q && (8'(card_q) < {3'b000, plim_q}));
		stat.hit_scan_end = (i_q >= hit_used_q);
		stat.hit_match    = (hit_rd_q.id == cur_id_q);
		stat.sel_more     = (8'(n_q) < lim8);
		stat.sel_got      = got_q;
		stat.pend_valid   = pend_valid_q;
		stat.out_free     = out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q <= TOP_LIMIT_RST;
			plim_q <= POSTING_LIMIT_RST;
			kmer_q <= '0;
			present_q <= 1'b0;
			end_q <= 1'b0;
			in_read_q <= 1'b0;
			is_ref_q <= 1'b0;
			read_acc_q <= 1'b0;
			ref_id_q <= '0;
			ref_cnt_q <= '0;
			read_cnt_q <= '0;
			ovf_q <= 1'b0;
			hit_used_q <= '0;
			i_q <= '0;
			acc_q <= '0;
			hd_q <= '0;
			p_q <= '0;
			slot_q <= '0;
			clr_q <= '0;
			found_q <= 1'b0;
			free_q <= 1'b0;
			card_q <= '0;
			j_q <= '0;
			post_base_q <= '0;
			cur_id_q <= '0;
			got_q <= 1'b0;
			have_prev_q <= 1'b0;
			pend_valid_q <= 1'b0;
			best_id_q <= '0;
			best_cnt_q <= '0;
			prev_id_q <= '0;
			prev_cnt_q <= '0;
			pend_id_q <= '0;
			pend_cnt_q <= '0;
			n_q <= '0;
			res_valid_q <= 1'b0;
			res_rn_q <= '0;
			res_id_q <= '0;
			res_cnt_q <= '0;
			res_none_q <= 1'b0;
			res_ovf_q <= 1'b0;
			res_last_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_TOP_LIMIT:     top_q <= cfg_data;
					REG_POSTING_LIMIT: plim_q <= cfg_data;
					default: ;
				endcase
			end
			if (res_load) res_valid_q <= 1'b1;
			else if (res_valid_q && res_ready) res_valid_q <= 1'b0;

			unique case (cmd.op)
				OP_CLEAR: clr_q <= clr_q + IW'(1);
				OP_LOAD: begin
					kmer_q <= kmer_value;
					present_q <= kmer_present;
					end_q <= read_end;
					acc_q <= '0;
					hd_q <= '0;
					p_q <= '0;
					found_q <= 1'b0;
					free_q <= 1'b0;
					card_q <= '0;
					j_q <= '0;
					if (!in_read_q) begin
						in_read_q <= 1'b1;
						is_ref_q <= command;
						read_acc_q <= command || accept_reference;
						if (command || accept_reference) begin
							ref_id_q <= ref_cnt_q;
							ref_cnt_q <= ref_cnt_q + ID_BITS'(1);
						end
					end
				end
				OP_HASH: begin
					acc_q <= acc_q + (hash_part << {hd_q, 4'b0000});
					hd_q <= hd_q + 2'd1;
				end
				OP_PROBE_CHK: begin
					if (!idx_rd_q.valid || key_match) begin
						found_q <= key_match;
						free_q <= !idx_rd_q.valid;
						slot_q <= probe_addr;
						card_q <= key_match ? idx_rd_q.cnt : '0;
						post_base_q <= PA_W'(probe_addr) * PA_W'(POSTINGS_PER_KMER);
					end else if (p_q != PROBE_W'(PROBE_DEPTH - 1)) begin
						p_q <= p_q + PROBE_W'(1);
					end
				end
				OP_POST_CAP: begin
					cur_id_q <= post_rd_q;
					i_q <= '0;
				end
				OP_HIT_CHK: begin
					if (hit_rd_q.id != cur_id_q) i_q <= i_q + HU_W'(1);
				end
				OP_HIT_NEW: begin
					if (hit_full) ovf_q <= 1'b1;
					else hit_used_q <= hit_used_q + HU_W'(1);
				end
				OP_POST_NEXT: j_q <= j_q + PC_W'(1);
				OP_INSERT: begin
					if (!ins_room) ovf_q <= 1'b1;
				end
				OP_SEL_START: begin
					n_q <= '0;
					have_prev_q <= 1'b0;
					pend_valid_q <= 1'b0;
				end
				OP_SEL_INIT: begin
					i_q <= '0;
					got_q <= 1'b0;
				end
				OP_SEL_CHK: begin
					if (eligible && better) begin
						got_q <= 1'b1;
						best_id_q <= hit_rd_q.id;
						best_cnt_q <= hit_rd_q.cnt;
					end
					i_q <= i_q + HU_W'(1);
				end
				OP_SEL_EMIT: begin
					if (pend_valid_q) begin
						res_rn_q <= read_cnt_q;
						res_id_q <= cid_ext[OUT_ID_W-1:0];
						res_cnt_q <= pend_cnt_q;
						res_none_q <= 1'b0;
						res_ovf_q <= ovf_q;
						res_last_q <= 1'b0;
					end
					pend_valid_q <= 1'b1;
					pend_id_q <= best_id_q;
					pend_cnt_q <= best_cnt_q;
					prev_id_q <= best_id_q;
					prev_cnt_q <= best_cnt_q;
					have_prev_q <= 1'b1;
					n_q <= n_q + TN_W'(1);
				end
				OP_FLUSH: begin
					res_rn_q <= read_cnt_q;
					res_id_q <= pend_valid_q ? cid_ext[OUT_ID_W-1:0] : '0;
					res_cnt_q <= pend_valid_q ? pend_cnt_q : '0;
					res_none_q <= !pend_valid_q;
					res_ovf_q <= ovf_q;
					res_last_q <= 1'b1;
					read_cnt_q <= read_cnt_q + OUT_ID_W'(1);
					hit_used_q <= '0;
					ovf_q <= 1'b0;
					in_read_q <= 1'b0;
				end
				OP_READ_DONE: begin
					read_cnt_q <= read_cnt_q + OUT_ID_W'(1);
					hit_used_q <= '0;
					ovf_q <= 1'b0;
					in_read_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	assign res_valid      = res_valid_q;
	assign read_number    = res_rn_q;
	assign candidate_id   = res_id_q;
	assign shared_count   = res_cnt_q;
	assign no_candidate   = res_none_q;
	assign overflow       = res_ovf_q;
	assign last_candidate = res_last_q;

endmodule

/* hdl/kmer_index_top_candidates.sv */
// per k-mer: load, hash and linear probe (a reference insert included); a query k-mer adds
//   an insert when accepted, and per posting a walk of the hit entries, plus a write for a new id
// read end: per reported candidate a pass over the hit table, a closing pass when fewer than
//   min(top_limit, TOP_MAX) are found, then a flush once the output register is free
// throughput: one request at a time; an item with no k-mer skips the hash and probe
// reset: arst_n clears control state, then the index clears its INDEX_ENTRIES slots, one slot a cycle
module kmer_index_top_candidates import kitc_pkg::*; #(
	parameter int INDEX_ENTRIES     = 4096,
	parameter int POSTINGS_PER_KMER = 16,
	parameter int HIT_ENTRIES       = 256,
	parameter int TOP_MAX           = 16,
	parameter int ID_BITS           = 20
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	kitc_in_if.sink              item,
	kitc_out_if.source           result
);

	// command and status between the sequencer and the datapath
	kitc_cmd_t  cmd;
	kitc_stat_t stat;

	// sequencer: hash, probe, posting walk, hit update, insert, top selection
	kitc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.in_ready (item.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// datapath: k-mer index, posting lists and per-read hit table, plus output register
	// the index is a hashed table probed linearly over eight slots (index size a power of two)
	kitc_dp #(
		.INDEX_ENTRIES     (INDEX_ENTRIES),
		.POSTINGS_PER_KMER (POSTINGS_PER_KMER),
		.HIT_ENTRIES       (HIT_ENTRIES),
		.TOP_MAX           (TOP_MAX),
		.ID_BITS           (ID_BITS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.cmd              (cmd),
		.stat             (stat),
		.command          (item.command),
		.kmer_value       (item.kmer_value),
		.kmer_present     (item.kmer_present),
		.read_end         (item.read_end),
		.accept_reference (item.accept_reference),
		.res_valid        (result.valid),
		.res_ready        (result.ready),
		.read_number      (result.read_number),
		.candidate_id     (result.candidate_id),
		.shared_count     (result.shared_count),
		.no_candidate     (result.no_candidate),
		.overflow         (result.overflow),
		.last_candidate   (result.last_candidate)
	);

endmodule
